// File: rtl/shabs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: shared package
// Sequencer states, the core control group, the initial hash vector and the
// round constant table.
// ----------------------------------------------------------------------------
package shabs_pkg;

  // Eight 32-bit words, index 0 holds word A / H0
  typedef logic [7:0][31:0] shabs_words_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS_HASH,
    ST_PAD,
    ST_PAD_HASH,
    ST_EMIT
  } shabs_state_e;

  // Control group from the sequencer to the compression core
  typedef struct packed {
    logic       byte_shift;
    logic [7:0] byte_val;
    logic       start;
    logic       h_init;
  } shabs_core_ctrl_t;

  localparam logic       MODE_ABSORB = 1'b0;
  localparam logic       MODE_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] ROUND_LAST  = 6'd63;
  localparam logic [2:0] WORD_LAST   = 3'd7;

  localparam shabs_words_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// File: rtl/shabs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Block buffer as a byte shift line, one shared round unit run for 64 rounds,
// message schedule in the same buffer, chaining add as a separate registered step.
// ----------------------------------------------------------------------------
module shabs_core import shabs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  shabs_core_ctrl_t ctrl_i,
  output logic             busy_o,
  output shabs_words_t     h_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [511:0] blk_q, blk_d;
  shabs_words_t h_q, h_d, v_q, v_d;
  logic [5:0]   rnd_q;
  logic         run_q, fin_q;

  logic [31:0]  w_t, w_new, t1, t2, s0, s1, bs0, bs1, ch, maj;

  always_comb begin
    w_t   = blk_q[511:480];
    s0    = rotr(blk_q[479:448], 7) ^ rotr(blk_q[479:448], 18) ^ (blk_q[479:448] >> 3);
    s1    = rotr(blk_q[63:32], 17) ^ rotr(blk_q[63:32], 19) ^ (blk_q[63:32] >> 10);
    w_new = w_t + s0 + blk_q[223:192] + s1;

    bs1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    bs0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + bs1 + ch + ROUND_K[rnd_q] + w_t;
    t2  = bs0 + maj;

    blk_d = blk_q;
    v_d   = v_q;
    h_d   = h_q;

    // Advance the schedule window while rounds run, else take message bytes
    if (run_q) begin
      blk_d  = {blk_q[479:0], w_new};
      v_d[0] = t1 + t2;
      v_d[1] = v_q[0];
      v_d[2] = v_q[1];
      v_d[3] = v_q[2];
      v_d[4] = v_q[3] + t1;
      v_d[5] = v_q[4];
      v_d[6] = v_q[5];
      v_d[7] = v_q[6];
    end else if (ctrl_i.byte_shift) begin
      blk_d = {blk_q[503:0], ctrl_i.byte_val};
    end

    if (ctrl_i.start) begin
      v_d = h_q;
    end

    if (fin_q) begin
      for (int i = 0; i < 8; i++) begin
        h_d[i] = h_q[i] + v_q[i];
      end
    end

    if (ctrl_i.h_init) begin
      h_d = HASH_IV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= HASH_IV;
      rnd_q <= '0;
      run_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      h_q   <= h_d;
      fin_q <= 1'b0;
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == ROUND_LAST) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    v_q   <= v_d;
  end

  assign busy_o = run_q | fin_q;
  assign h_o    = h_q;

endmodule

// File: rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs a message one byte per transfer and returns the eight digest words
// of SHA-256 on a finish transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): mode_i = 0 absorbs message_byte_i,
//   mode_i = 1 finishes the message; message_byte_i is ignored then.
//   Output channel (out_valid_o / out_stall_i): eight transfers per finish,
//   digest_word_o = H0..H7 with word_index_o, last_word_o set on H7.
// Timing:
//   The 64th byte of a block starts the shared round unit: 64 rounds at one
//   per cycle, then the chaining add, then the handoff back to idle.
//   A finish shifts padding and length bytes into the block buffer, one per
//   cycle except while a compression runs (64 minus pending bytes, or 128
//   minus them when 56 or more are pending), runs one or two compressions,
//   then offers the eight words once the last chaining add is done.
//   in_stall_o stays high from any block-completing transfer to the end of
//   its compression, and from a finish until H7 has been transferred.
// Reset: the chaining words take the initial hash vector, the byte and bit
//   counts clear, no digest is pending. out_stall_i holds the current word
//   in place; the block simply waits.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher import shabs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  message_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  shabs_state_e     state_q, state_d;
  logic [5:0]       fill_q, fill_d;
  logic [63:0]      bits_q, bits_d;
  logic             two_blk_q, two_blk_d;
  logic             final_q, final_d;
  logic [2:0]       idx_q, idx_d;

  shabs_core_ctrl_t ctrl;
  logic             busy;
  shabs_words_t     h_words;
  logic             in_xfer, out_xfer;
  logic [7:0]       len_byte;

  shabs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .busy_o (busy),
    .h_o    (h_words)
  );

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign in_xfer       = in_valid_i & ~in_stall_o;
  assign out_xfer      = out_valid_o & ~out_stall_i;
  assign digest_word_o = h_words[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == WORD_LAST);

  // Length bytes go out big-endian: buffer slot 56 carries bits 63:56
  assign len_byte = 8'(bits_q >> {~fill_q[2:0], 3'b000});

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bits_d    = bits_q;
    two_blk_d = two_blk_q;
    final_d   = final_q;
    idx_d     = idx_q;
    ctrl      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          ctrl.byte_shift = 1'b1;
          fill_d          = fill_q + 6'd1;
          if (mode_i == MODE_ABSORB) begin
            ctrl.byte_val = message_byte_i;
            bits_d        = bits_q + 64'd8;
            if (fill_q == FILL_LAST) begin
              ctrl.start = 1'b1;
              state_d    = ST_ABS_HASH;
            end
          end else begin
            // Pad byte first; it may itself complete the block
            ctrl.byte_val = PAD_BYTE;
            if (fill_q == FILL_LAST) begin
              ctrl.start = 1'b1;
              final_d    = 1'b0;
              two_blk_d  = 1'b0;
              state_d    = ST_PAD_HASH;
            end else begin
              two_blk_d = (fill_q inside {[LEN_POS:FILL_LAST]});
              state_d   = ST_PAD;
            end
          end
        end
      end

      ST_ABS_HASH: begin
        if (!busy) begin
          state_d = ST_IDLE;
        end
      end

      ST_PAD: begin
        ctrl.byte_shift = 1'b1;
        fill_d          = fill_q + 6'd1;
        if (!two_blk_q && (fill_q inside {[LEN_POS:FILL_LAST]})) begin
          ctrl.byte_val = len_byte;
        end else begin
          ctrl.byte_val = 8'h00;
        end
        if (fill_q == FILL_LAST) begin
          ctrl.start = 1'b1;
          final_d    = ~two_blk_q;
          two_blk_d  = 1'b0;
          state_d    = ST_PAD_HASH;
        end
      end

      ST_PAD_HASH: begin
        if (!busy) begin
          state_d = final_q ? ST_EMIT : ST_PAD;
        end
      end

      ST_EMIT: begin
        if (out_xfer) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == WORD_LAST) begin
            // Drop back to a fresh message
            ctrl.h_init = 1'b1;
            fill_d      = '0;
            bits_d      = '0;
            idx_d       = '0;
            state_d     = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      bits_q    <= '0;
      two_blk_q <= 1'b0;
      final_q   <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      bits_q    <= bits_d;
      two_blk_q <= two_blk_d;
      final_q   <= final_d;
      idx_q     <= idx_d;
    end
  end

endmodule

// File: rtl/shabs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: port checker
// Watches the top level ports for ordering of digest words against inputs.
// ----------------------------------------------------------------------------
module shabs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_xfer = out_valid_o & ~out_stall_i;

  // No input transfer while a digest is still being delivered
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_xfer && out_valid_o))
    else $error("input transfer while digest pending");

  // A finish blocks further input on the next cycle
  a_finish_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mode_i) |=> in_stall_o)
    else $error("input not stalled after finish");

  // A digest always starts at H0
  a_start_word0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (word_index_o == 3'd0))
    else $error("digest does not start at word 0");

  // Words advance by one after each non-final transfer
  a_word_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !last_word_o) |=>
      (out_valid_o && (word_index_o == $past(word_index_o) + 3'd1)))
    else $error("digest word sequence broken");

  // The last word ends the digest
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_word_o) |=> !out_valid_o)
    else $error("output still valid after last word");

endmodule

bind sha256_byte_stream_hasher shabs_checker u_shabs_checker (.*);

// File: sim/tb_sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: SHA-256 byte stream hasher
// Streams messages into the hasher one byte per transfer, closes each with a
// finish transfer, and checks all eight digest words against a SHA-256
// predictor that runs inside the bench. Both channels idle at random, except
// during one stretch of the random phase that runs at full rate.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher import shabs_pkg::*;;

  // Clock period is 20 ns. The longest quiet span of a correct run is a finish
  // with 56 or more bytes pending: padding shifts for two blocks, two
  // compressions and a short handoff. Allow several times that span, plus
  // sender gaps and receiver stalls.
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 93;
  localparam int unsigned IDLE_PCT     = 35;

  typedef logic [0:63][7:0] block_t;
  typedef logic [0:7][31:0] words_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_rec_t;

  localparam words_t SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Block ports; the inputs are at known values from time zero
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        mode_i         = MODE_ABSORB;
  logic [7:0]  message_byte_i = 8'h00;
  logic        out_stall_i    = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // Hash state as the predictor sees it
  words_t      chain_h   = SHA_IV;
  block_t      block_buf = '0;
  int unsigned block_fill = 0;
  logic [63:0] msg_bits  = '0;

  digest_rec_t digest_q [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  logic        gaps_on        = 1'b1;

  sha256_byte_stream_hasher i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .message_byte_i (message_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // SHA-256 predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds on one block and fold the result into chain_h
  function automatic void sha_compress(input block_t blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    {a, b, c, d, e, f, g, h} = chain_h;
    for (i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  // Apply one accepted transfer to the predicted state; a finish queues the
  // eight digest words and starts a fresh message.
  function automatic void hash_transfer(input logic mode, input logic [7:0] data);
    block_t pad;
    digest_rec_t rec;
    int k;
    if (mode == MODE_ABSORB) begin
      block_buf[block_fill] = data;
      msg_bits += 64'd8;
      block_fill++;
      if (block_fill == 64) begin
        sha_compress(block_buf);
        block_fill = 0;
      end
    end else begin
      pad = block_buf;
      for (k = block_fill; k < 64; k++) pad[k] = 8'h00;
      pad[block_fill] = PAD_BYTE;
      // No room left for the length field: spill into a second block
      if (block_fill >= LEN_POS) begin
        sha_compress(pad);
        pad = '0;
      end
      pad[56:63] = msg_bits;
      sha_compress(pad);
      for (k = 0; k < 8; k++) begin
        rec = '{digest_word: chain_h[k], word_index: 3'(k),
                last_word: (k == WORD_LAST)};
        digest_q = {digest_q, rec};
      end
      chain_h    = SHA_IV;
      block_fill = 0;
      msg_bits   = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  // Called at a falling edge. Valid stays high on return so that back-to-back
  // transfers never lower and raise it within one time step; a gap or the end
  // of the run lowers it.
  task automatic send_transfer(input logic mode, input logic [7:0] data);
    while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    message_byte_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    hash_transfer(mode, data);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, result check, watchdog
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin : digest_check
    digest_rec_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("digest word with none expected: digest_word %h word_index %0d",
                 digest_word_o, word_index_o);
          mismatch_count++;
        end else begin
          want = digest_q.pop_front();
          if (digest_word_o !== want.digest_word) begin
            $error("digest_word: expected %h, actual %h", want.digest_word, digest_word_o);
            mismatch_count++;
          end
          if (word_index_o !== want.word_index) begin
            $error("word_index: expected %0d, actual %0d", want.word_index, word_index_o);
            mismatch_count++;
          end
          if (last_word_o !== want.last_word) begin
            $error("last_word: expected %0b, actual %0b", want.last_word, last_word_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Stop a hung run: nothing transferred on either side for too long
  always @(posedge clk_i) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Finish with nothing absorbed twice in a row: digest of the empty string,
  // state back to the initial vector after a finish, and the byte on a finish
  // transfer ignored (all zeros, then all ones).
  task automatic test_empty_message();
    send_transfer(MODE_FINISH, 8'h00);
    send_transfer(MODE_FINISH, 8'hff);
  endtask

  // Byte extremes and the pad value itself as message content
  task automatic test_byte_extremes();
    send_transfer(MODE_ABSORB, 8'h00);
    send_transfer(MODE_ABSORB, 8'hff);
    send_transfer(MODE_ABSORB, 8'h80);
    send_transfer(MODE_ABSORB, 8'h7f);
    send_transfer(MODE_ABSORB, 8'h01);
    send_transfer(MODE_ABSORB, 8'hfe);
    send_transfer(MODE_FINISH, 8'h5a);
  endtask

  // Same short message twice: a finish after real data must clear the
  // chaining words, the byte count and the bit count.
  task automatic test_after_finish();
    int n, k;
    for (n = 0; n < 2; n++) begin
      for (k = 0; k < 3; k++) send_transfer(MODE_ABSORB, 8'h61 + 8'(k));
      send_transfer(MODE_FINISH, 8'(n));
    end
  endtask

  // Random messages. Most are short; about one in four is long enough to fill
  // the length field area (second pad block) or a whole block. The first one
  // always spills the padding. The last message is cut to fit the item budget.
  // The middle of the run drops all idling on both sides. The 2^64-bit count
  // wrap is out of reach in simulation.
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned msg_len;
    int unsigned k;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0) begin
        msg_len = $urandom_range(63, 56);
      end else if ($urandom_range(3) == 0) begin
        msg_len = $urandom_range(72, 55);
      end else begin
        msg_len = $urandom_range(12, 0);
      end
      if (msg_len >= RANDOM_ITEMS - sent) begin
        msg_len = RANDOM_ITEMS - sent - 1;
      end
      for (k = 0; k <= msg_len; k++) begin
        gaps_on = !(sent >= 35 && sent < 75);
        if (k == msg_len) begin
          send_transfer(MODE_FINISH, 8'($urandom_range(255)));
        end else begin
          send_transfer(MODE_ABSORB, 8'($urandom_range(255)));
        end
        sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_message();
    test_byte_extremes();
    test_after_finish();
    test_random_messages();

    in_valid_i <= 1'b0;
    // Drain the digest words, then hold off long enough to catch strays
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
